@@ hw/rtl/reed_solomon_check_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// reed-solomon check encoder assertion macros
// Shared property wrappers for the encoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef REED_SOLOMON_CHECK_ENCODER_MACROS_SVH
`define REED_SOLOMON_CHECK_ENCODER_MACROS_SVH

// same-cycle implication, disabled in reset
`define RSCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rs check encoder: same-cycle check failed");

// next-cycle implication, disabled in reset
`define RSCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rs check encoder: next-cycle check failed");

`endif

@@ hw/rtl/rsce_pkg.sv @@
// ----------------------------------------------------------------------------
// rsce_pkg
// Beat types, field constants and GF(256) helpers for the check encoder.
// ----------------------------------------------------------------------------
package rsce_pkg;

    localparam logic [8:0] C_FIELD_POLY = 9'h11D;
    localparam int         C_EC_RESET   = 10;
    localparam int         C_EC_W       = 6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] check_byte;
        logic       last_check;
    } t_out_beat;

    // per-cycle controls broadcast to every cell
    typedef struct packed {
        logic clear;
        logic build;
        logic fold;
        logic flush;
        logic load;
        logic shift;
    } t_cell_ctrl;

    function automatic logic [7:0] gf_xtime(input logic [7:0] x);
        logic [7:0] r;
        r = {x[6:0], 1'b0};
        if (x[7]) begin
            r = r ^ C_FIELD_POLY[7:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = '0;
        x   = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

endpackage

@@ hw/rtl/rsce_cell.sv @@
// ----------------------------------------------------------------------------
// rsce_cell
// One LFSR stage: a generator coefficient, a remainder byte and an output
// byte, with one shared GF(256) multiplier for folding and generator build.
// ----------------------------------------------------------------------------
module rsce_cell
    import rsce_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic [7:0] i_factor,
    input  logic [7:0] i_root,
    input  logic [7:0] i_g_prev,
    input  logic [7:0] i_rem_next,
    input  logic [7:0] i_out_next,
    output logic [7:0] o_g,
    output logic [7:0] o_rem,
    output logic [7:0] o_out
);

    logic [7:0] r_g;
    logic [7:0] r_rem;
    logic [7:0] r_out;
    logic [7:0] n_g;
    logic [7:0] n_rem;
    logic [7:0] n_out;
    logic [7:0] w_mul_a;
    logic [7:0] w_mul_b;
    logic [7:0] w_prod;
    logic [7:0] w_rem_new;

    // build: g[i] ^= g[i-1] * root, run: neighbor remainder ^ g[i] * factor
    assign w_mul_a   = i_ctrl.build ? i_g_prev : r_g;
    assign w_mul_b   = i_ctrl.build ? i_root   : i_factor;
    assign w_prod    = gf_mul(w_mul_a, w_mul_b);
    assign w_rem_new = i_rem_next ^ w_prod;

    always_comb begin
        n_g   = r_g;
        n_rem = r_rem;
        n_out = r_out;
        if (i_ctrl.clear) begin
            n_g   = '0;
            n_rem = '0;
        end else if (i_ctrl.build) begin
            n_g = r_g ^ w_prod;
        end else if (i_ctrl.fold) begin
            n_rem = i_ctrl.flush ? 8'h00 : w_rem_new;
        end
        if (i_ctrl.load) begin
            n_out = w_rem_new;
        end else if (i_ctrl.shift) begin
            n_out = i_out_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g   <= n_g;
        r_rem <= n_rem;
        r_out <= n_out;
    end

    assign o_g   = r_g;
    assign o_rem = r_rem;
    assign o_out = r_out;

endmodule

@@ hw/rtl/reed_solomon_check_encoder.sv @@
// ----------------------------------------------------------------------------
// reed_solomon_check_encoder
// Systematic RS(GF(256), 0x11D) check-byte encoder built as a row of LFSR
// cells; generator roots alpha^0 .. alpha^(n-1).
//
//   channel   signals                          direction
//   data in   i_valid, o_stall, i_data         message bytes
//   check out o_valid, i_stall, o_data         check bytes, highest first
//   config    i_cfg_we, i_cfg_wdata            ec_count
//
// One message byte per cycle while o_stall is low: the whole cell row folds a byte at once.
// A last byte copies the remainder into the output row, which shifts out
// n bytes (ec_count clamped to 1..MAX_CHECK), one per cycle unless i_stall holds them, while the
// next block is folded in.
// A last byte also stalls while the previous block's check bytes drain.
// After reset, and after each ec_count write, the generator is rebuilt from its
// n roots (ten after reset), with input stalled while the rebuild runs.
// ----------------------------------------------------------------------------
`include "reed_solomon_check_encoder_macros.svh"

module reed_solomon_check_encoder
    import rsce_pkg::*;
#(
    parameter int MAX_CHECK = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [C_EC_W-1:0] i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_beat          i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_beat         o_data
);

    localparam int DEG_W   = $clog2(MAX_CHECK + 1);
    localparam int CMP_W   = (DEG_W > C_EC_W) ? DEG_W : C_EC_W;
    localparam int RST_DEG = (C_EC_RESET > MAX_CHECK) ? MAX_CHECK : C_EC_RESET;

    logic [DEG_W-1:0] r_deg;
    logic [DEG_W-1:0] n_deg;
    logic [DEG_W-1:0] r_bcnt;
    logic [DEG_W-1:0] n_bcnt;
    logic [DEG_W-1:0] r_cnt;
    logic [DEG_W-1:0] n_cnt;
    logic [7:0]       r_root;
    logic [7:0]       n_root;

    logic [CMP_W-1:0] w_cfg_ext;
    logic [DEG_W-1:0] w_cfg_deg;
    logic             w_building;
    logic             w_load_ok;
    logic             w_acc_in;
    logic             w_acc_last;
    logic             w_take;
    logic [7:0]       w_factor;
    t_cell_ctrl       w_ctrl;

    logic [7:0] w_g   [MAX_CHECK];
    logic [7:0] w_rem [MAX_CHECK];
    logic [7:0] w_out [MAX_CHECK];

    // ec_count of zero acts as one, above the cell count saturates
    assign w_cfg_ext = CMP_W'(i_cfg_wdata);
    always_comb begin
        if (w_cfg_ext == '0) begin
            w_cfg_deg = DEG_W'(1);
        end else if (w_cfg_ext > CMP_W'(MAX_CHECK)) begin
            w_cfg_deg = DEG_W'(MAX_CHECK);
        end else begin
            w_cfg_deg = w_cfg_ext[DEG_W-1:0];
        end
    end

    assign w_building = (r_bcnt != '0);
    assign o_valid    = (r_cnt != '0);
    assign w_take     = o_valid & ~i_stall;
    assign w_load_ok  = (r_cnt == '0) | ((r_cnt == DEG_W'(1)) & w_take);
    assign o_stall    = ~i_rst_n | w_building | (i_data.last_byte & ~w_load_ok);
    assign w_acc_in   = i_valid & ~o_stall;
    assign w_acc_last = w_acc_in & i_data.last_byte;
    assign w_factor   = i_data.data_byte ^ w_rem[0];

    always_comb begin
        w_ctrl.clear = ~i_rst_n | i_cfg_we;
        w_ctrl.build = w_building;
        w_ctrl.fold  = w_acc_in;
        w_ctrl.flush = w_acc_last;
        w_ctrl.load  = w_acc_last;
        w_ctrl.shift = w_take;
    end

    always_comb begin
        n_deg  = r_deg;
        n_bcnt = r_bcnt;
        n_root = r_root;
        n_cnt  = r_cnt;
        if (i_cfg_we) begin
            n_deg  = w_cfg_deg;
            n_bcnt = w_cfg_deg;
            n_root = 8'h01;
        end else if (w_building) begin
            n_bcnt = r_bcnt - DEG_W'(1);
            n_root = gf_xtime(r_root);
        end
        if (w_acc_last) begin
            n_cnt = r_deg;
        end else if (w_take) begin
            n_cnt = r_cnt - DEG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg  <= DEG_W'(RST_DEG);
            r_bcnt <= DEG_W'(RST_DEG);
            r_cnt  <= '0;
            r_root <= 8'h01;
        end else begin
            r_deg  <= n_deg;
            r_bcnt <= n_bcnt;
            r_cnt  <= n_cnt;
            r_root <= n_root;
        end
    end

    // cell i holds generator term i+1, the leading 1 sits left of cell 0
    for (genvar i = 0; i < MAX_CHECK; i++) begin : g_cell
        logic [7:0] w_g_prev;
        logic [7:0] w_rem_next;
        logic [7:0] w_out_next;

        if (i == 0) begin : g_head
            assign w_g_prev = 8'h01;
        end else begin : g_mid
            assign w_g_prev = w_g[i-1];
        end

        if (i == MAX_CHECK - 1) begin : g_tail
            assign w_rem_next = 8'h00;
            assign w_out_next = 8'h00;
        end else begin : g_body
            assign w_rem_next = w_rem[i+1];
            assign w_out_next = w_out[i+1];
        end

        rsce_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_factor   (w_factor),
            .i_root     (r_root),
            .i_g_prev   (w_g_prev),
            .i_rem_next (w_rem_next),
            .i_out_next (w_out_next),
            .o_g        (w_g[i]),
            .o_rem      (w_rem[i]),
            .o_out      (w_out[i])
        );
    end

    assign o_data.check_byte = w_out[0];
    assign o_data.last_check = (r_cnt == DEG_W'(1));

    `RSCE_ASSERT_NOW(a_no_fold_in_build, i_clk, i_rst_n, w_building, !w_acc_in)
    `RSCE_ASSERT_NEXT(a_last_loads_drain, i_clk, i_rst_n, w_acc_last, o_valid && (r_cnt == r_deg))
    `RSCE_ASSERT_NEXT(a_cfg_starts_build, i_clk, i_rst_n, i_cfg_we, w_building && (r_bcnt == r_deg))
    `RSCE_ASSERT_NEXT(a_drain_ends, i_clk, i_rst_n, w_take && o_data.last_check && !w_acc_last, !o_valid)

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the GF(256) Reed-Solomon check-byte encoder: a
// byte-level LFSR model predicts the check bytes of every block, and each
// output beat is compared with the oldest prediction, under random idling
// on both channels and several ec_count settings.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsce_pkg::*;

    localparam int MAX_CHECK     = 32;
    localparam int SETTLE_CYCLES = MAX_CHECK + 8;
    localparam int QUIET_LIMIT   = 2000;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [C_EC_W-1:0] i_cfg_wdata = '0;
    logic              i_valid     = 1'b0;
    logic              o_stall;
    t_in_beat          i_data      = '0;
    logic              o_valid;
    logic              i_stall     = 1'b0;
    t_out_beat         o_data;

    // model state
    logic [7:0]  rem_bytes [MAX_CHECK];
    logic [7:0]  gen_coef  [MAX_CHECK];
    int unsigned gen_degree;
    t_out_beat   pending_checks [$];
    t_out_beat   want_beat;

    int error_count  = 0;
    int quiet_cycles = 0;
    int stall_left   = 0;
    bit idle_on      = 1'b0;

    reed_solomon_check_encoder #(
        .MAX_CHECK (MAX_CHECK)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // msb-first horner form of the field product
    function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int k = 7; k >= 0; k--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? C_FIELD_POLY[7:0] : 8'h00);
            if (b[k]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

    // rebuild generator (roots alpha^0 .. alpha^(n-1)) and clear the remainder
    function automatic void set_check_count(input int unsigned value);
        logic [7:0] poly [MAX_CHECK+1];
        logic [7:0] root;
        gen_degree = (value == 0) ? 1 : ((value > MAX_CHECK) ? MAX_CHECK : value);
        foreach (poly[i]) begin
            poly[i] = 8'h00;
        end
        poly[0] = 8'h01;
        root    = 8'h01;
        for (int i = 0; i < gen_degree; i++) begin
            for (int j = i + 1; j > 0; j--) begin
                poly[j] = poly[j] ^ field_mul(poly[j-1], root);
            end
            root = field_mul(root, 8'h02);
        end
        for (int i = 0; i < MAX_CHECK; i++) begin
            gen_coef[i]  = (i < gen_degree) ? poly[i+1] : 8'h00;
            rem_bytes[i] = 8'h00;
        end
    endfunction

    function automatic void fold_message_byte(input t_in_beat beat);
        logic [7:0] factor;
        t_out_beat  check;
        factor = beat.data_byte ^ rem_bytes[0];
        for (int i = 0; i + 1 < gen_degree; i++) begin
            rem_bytes[i] = rem_bytes[i+1];
        end
        rem_bytes[gen_degree-1] = 8'h00;
        for (int i = 0; i < gen_degree; i++) begin
            rem_bytes[i] = rem_bytes[i] ^ field_mul(gen_coef[i], factor);
        end
        if (beat.last_byte) begin
            for (int i = 0; i < gen_degree; i++) begin
                check.check_byte = rem_bytes[i];
                check.last_check = (i + 1 == gen_degree);
                pending_checks = {pending_checks, check};
                rem_bytes[i] = 8'h00;
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic send_byte(input logic [7:0] value, input bit last);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = '{data_byte: value, last_byte: last};
        do @(posedge i_clk); while (o_stall !== 1'b0);
        fold_message_byte(i_data);
    endtask

    task automatic send_block(input int len);
        for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    // drop valid, wait for every predicted beat, optionally let the block go quiet
    task automatic wait_results(input bit settle);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_checks.size() != 0) @(posedge i_clk);
        if (settle) begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic write_check_count(input int unsigned value);
        wait_results(1'b1);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value[C_EC_W-1:0];
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        set_check_count(int'(value[C_EC_W-1:0]));
    endtask

    task automatic test_reset_generator();
        idle_on = 1'b1;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        // one-byte block
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_degree_limits();
        int unsigned values [6] = '{0, 1, 32, 63, 33, 2};
        foreach (values[i]) begin
            write_check_count(values[i]);
            send_byte(8'hFF, 1'b0);
            send_byte(8'h01, 1'b1);
        end
    endtask

    // a write in the middle of a block discards the partial remainder
    task automatic test_midblock_write();
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        write_check_count(7);
        send_byte(8'hAB, 1'b1);
    endtask

    // last bytes back to back stall while the previous block drains
    task automatic test_back_to_back();
        write_check_count(32);
        idle_on = 1'b0;
        send_byte(8'h80, 1'b1);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hC3, 1'b1);
        wait_results(1'b0);
    endtask

    task automatic run_random_phase(input int n_items, input bit idle);
        int sent;
        int len;
        int choice;
        idle_on = idle;
        sent    = 0;
        while (sent < n_items) begin
            choice = $urandom_range(0, 9);
            if (choice == 0) begin
                write_check_count($urandom_range(0, 63));
            end else if (choice == 1) begin
                write_check_count($urandom_range(1, 4));
            end else if (choice == 2) begin
                wait_results(1'b0);
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if ($urandom_range(0, 9) == 0) begin
                // abandoned block, cut off by a register write
                for (int k = 0; k < len; k++) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                write_check_count($urandom_range(0, 63));
            end else begin
                send_block(len);
            end
            sent += len;
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(45, 1'b1);
        run_random_phase(15, 1'b0);
        run_random_phase(25, 1'b1);
        run_random_phase(20, 1'b0);
    endtask

    // output side stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall = 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            i_stall    = 1'b1;
        end else begin
            i_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_checks.size() == 0) begin
                report_mismatch("check beat with nothing expected");
            end else begin
                want_beat = pending_checks.pop_front();
                if (o_data.check_byte !== want_beat.check_byte) begin
                    report_mismatch($sformatf("check_byte got %02h want %02h",
                                              o_data.check_byte, want_beat.check_byte));
                end
                if (o_data.last_check !== want_beat.last_check) begin
                    report_mismatch($sformatf("last_check got %b want %b",
                                              o_data.last_check, want_beat.last_check));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        set_check_count(C_EC_RESET);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_generator();
        test_degree_limits();
        test_midblock_write();
        test_back_to_back();
        test_random_traffic();

        wait_results(1'b1);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
